// ===== rtl/frd_pkg.sv =====
package frd_pkg;

  localparam logic [7:0] MAGIC_BYTE = 8'hAA;
  localparam int unsigned HDR_SLACK = 10;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_MAGIC = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_REQ   = 3'd4;

  localparam logic [1:0] REG_READ_MODE   = 2'd0;
  localparam logic [1:0] REG_REQUESTED   = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

  typedef enum logic [1:0] {
    K_DATA,
    K_START,
    K_BAD_REQ,
    K_BAD_MAGIC
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_SUM,
    PH_PAYLOAD
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

endpackage

// ===== rtl/frd_front.sv =====
module frd_front #(
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rec_byte_i,
  input  logic                 record_start_i,
  input  logic [19:0]          requested_len_i,
  input  logic [7:0]           block_count_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output frd_pkg::item_t       item_o
);
  import frd_pkg::*;

  localparam int LimW = $clog2(BLOCK_BYTES) + 9;
  localparam int CmpW = (LimW > 22) ? LimW : 22;

  logic [CmpW-1:0] limit;
  logic [CmpW-1:0] req_need;
  logic            bad_req;

  // limit of the record area: block size times block count
  assign limit    = CmpW'(BLOCK_BYTES) * {{(CmpW-8){1'b0}}, block_count_i};
  assign req_need = {{(CmpW-20){1'b0}}, requested_len_i} + CmpW'(HDR_SLACK);
  assign bad_req  = (block_count_i == 8'd0) || (requested_len_i == 20'd0) ||
                    (req_need > limit);

  always_comb begin
    item_o.data = rec_byte_i;
    if (!record_start_i) begin
      item_o.kind = K_DATA;
    end else if (bad_req) begin
      item_o.kind = K_BAD_REQ;
    end else if (rec_byte_i != MAGIC_BYTE) begin
      item_o.kind = K_BAD_MAGIC;
    end else begin
      item_o.kind = K_START;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

// ===== rtl/frd_queue.sv =====
module frd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  frd_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           not_empty_o,
  input  logic           pop_i,
  output frd_pkg::item_t pop_item_o
);
  import frd_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o      = (count_q == 2'd2);
  assign not_empty_o = (count_q != 2'd0);
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/frd_back.sv =====
module frd_back #(
  parameter int BLOCK_BYTES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_not_empty_i,
  input  frd_pkg::item_t item_i,
  output logic           pop_o,
  input  logic           read_mode_i,
  input  logic [19:0]    requested_len_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_byte_valid_o,
  output logic           done_res_o,
  output logic [2:0]     status_o,
  output logic [11:0]    payload_len_o
);
  import frd_pkg::*;

  localparam int RecW    = $clog2(BLOCK_BYTES - 9);
  localparam int BbW     = $clog2(BLOCK_BYTES + 1);
  localparam int LenCmpW = ((BbW > 17) ? BbW : 17) + 1;

  phase_e          state_q, state_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [RecW-1:0] rec_len_q, rec_len_d;
  logic [RecW-1:0] cnt_q, cnt_d;
  logic [7:0]      stored_sum_q, stored_sum_d;
  logic [7:0]      run_sum_q, run_sum_d;

  logic            out_valid_q;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_bv_q, out_bv_d;
  logic            done_q, done_d;
  logic [2:0]      status_q, status_d;
  logic [11:0]     plen_q, plen_d;

  logic [15:0]        len16;
  logic [LenCmpW-1:0] len_need;
  logic               len_err;
  logic [RecW-1:0]    cnt_nx;
  logic [7:0]         sum_nx;
  logic               keep;
  logic [15:0]        rec_len16;

  assign pop_o = q_not_empty_i && (!out_valid_q || !out_stall_i);

  assign len16     = {item_i.data, len_lo_q};
  assign len_need  = LenCmpW'(len16) + LenCmpW'(HDR_SLACK);
  assign len_err   = (len_need > LenCmpW'(BLOCK_BYTES)) ||
                     (read_mode_i && ({4'd0, len16} > requested_len_i));
  assign cnt_nx    = cnt_q + 1'b1;
  assign sum_nx    = run_sum_q + item_i.data;
  assign keep      = read_mode_i || (20'(cnt_q) < requested_len_i);
  assign rec_len16 = 16'(rec_len_q);

  always_comb begin
    state_d      = state_q;
    len_lo_d     = len_lo_q;
    rec_len_d    = rec_len_q;
    cnt_d        = cnt_q;
    stored_sum_d = stored_sum_q;
    run_sum_d    = run_sum_q;
    out_byte_d   = 8'd0;
    out_bv_d     = 1'b0;
    done_d       = 1'b0;
    status_d     = ST_OK;
    plen_d       = 12'd0;
    case (item_i.kind)
      K_BAD_REQ: begin
        state_d  = PH_IDLE;
        done_d   = 1'b1;
        status_d = ST_REQ;
      end
      K_BAD_MAGIC: begin
        state_d  = PH_IDLE;
        done_d   = 1'b1;
        status_d = ST_MAGIC;
      end
      K_START: begin
        // a new header aborts whatever record was in progress
        state_d = PH_LEN_LO;
      end
      K_DATA: begin
        case (state_q)
          PH_LEN_LO: begin
            len_lo_d = item_i.data;
            state_d  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (len_err) begin
              state_d  = PH_IDLE;
              done_d   = 1'b1;
              status_d = ST_LEN;
            end else begin
              rec_len_d = len16[RecW-1:0];
              state_d   = PH_SUM;
            end
          end
          PH_SUM: begin
            stored_sum_d = item_i.data;
            run_sum_d    = 8'd0;
            cnt_d        = '0;
            if (rec_len_q == '0) begin
              state_d  = PH_IDLE;
              done_d   = 1'b1;
              status_d = (item_i.data == 8'd0) ? ST_OK : ST_SUM;
            end else begin
              state_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            run_sum_d  = sum_nx;
            cnt_d      = cnt_nx;
            out_byte_d = keep ? item_i.data : 8'd0;
            out_bv_d   = keep;
            if (cnt_nx == rec_len_q) begin
              state_d  = PH_IDLE;
              done_d   = 1'b1;
              status_d = (sum_nx == stored_sum_q) ? ST_OK : ST_SUM;
              plen_d   = rec_len16[11:0];
            end
          end
          default: begin
            // padding between records: drop it with an empty beat
            state_d = PH_IDLE;
          end
        endcase
      end
      default: begin
        state_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= PH_IDLE;
      len_lo_q     <= 8'd0;
      rec_len_q    <= '0;
      cnt_q        <= '0;
      stored_sum_q <= 8'd0;
      run_sum_q    <= 8'd0;
    end else if (pop_o) begin
      state_q      <= state_d;
      len_lo_q     <= len_lo_d;
      rec_len_q    <= rec_len_d;
      cnt_q        <= cnt_d;
      stored_sum_q <= stored_sum_d;
      run_sum_q    <= run_sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_byte_q <= out_byte_d;
      out_bv_q   <= out_bv_d;
      done_q     <= done_d;
      status_q   <= status_d;
      plen_q     <= plen_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_byte_valid_o = out_bv_q;
  assign done_res_o       = done_q;
  assign status_o         = status_q;
  assign payload_len_o    = plen_q;

endmodule

// ===== rtl/flash_record_deframer_core.sv =====
// Record deframer: takes one stored byte per beat (magic 0xAA, length low,
// length high, additive checksum, payload) and returns exactly one result
// beat per input beat. It sustains one byte per clock cycle while the output
// is not stalled; a byte accepted at the input is written into the
// two-entry queue between the classifier and the record state machine, and
// from there moves through the record state machine into the output register
// once that register is free. The input stalls only when that queue is full.
// Payload bytes are forwarded as they arrive, so a consumer discards them
// when the final beat (done_res_o) carries a nonzero status. Registers (APB,
// 32-bit): 0x0 read_mode, 0x4 requested_len, 0x8 block_count; write them
// only while no record is in flight.
module flash_record_deframer_core #(
  parameter int BLOCK_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rec_byte_i,
  input  logic        record_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_byte_valid_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic [11:0] payload_len_o
);
  import frd_pkg::*;

  logic        read_mode_q;
  logic [19:0] requested_len_q;
  logic [7:0]  block_count_q;
  logic        cfg_wr;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_not_empty;
  logic  pop;
  item_t pop_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_mode_q     <= 1'b0;
      requested_len_q <= 20'd0;
      block_count_q   <= 8'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_READ_MODE:   read_mode_q     <= pwdata[0];
        REG_REQUESTED:   requested_len_q <= pwdata[19:0];
        REG_BLOCK_COUNT: block_count_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_READ_MODE:   prdata = {31'd0, read_mode_q};
      REG_REQUESTED:   prdata = {12'd0, requested_len_q};
      REG_BLOCK_COUNT: prdata = {24'd0, block_count_q};
      default:         prdata = 32'd0;
    endcase
  end

  frd_front #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rec_byte_i      (rec_byte_i),
    .record_start_i  (record_start_i),
    .requested_len_i (requested_len_q),
    .block_count_i   (block_count_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  frd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  frd_back #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_not_empty_i    (q_not_empty),
    .item_i           (pop_item),
    .pop_o            (pop),
    .read_mode_i      (read_mode_q),
    .requested_len_i  (requested_len_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .out_byte_valid_o (out_byte_valid_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .payload_len_o    (payload_len_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("queue written while full");

  a_status_only_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ST_OK && payload_len_o == 12'd0)
    else $error("status or length shown before end of record");

  a_dropped_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_byte_valid_o |-> out_byte_o == 8'd0)
    else $error("byte shown without byte valid");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !pop)
    else $error("result overwritten while stalled");

endmodule

// ===== sim/flash_record_deframer_core_tb.sv =====
`timescale 1ns / 100ps

module flash_record_deframer_core_tb;
  import frd_pkg::*;

  localparam int BLOCK_BYTES = 4096;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       hold_for_drain;
  } flash_beat_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        keep;
    logic        done;
    logic [2:0]  status;
    logic [11:0] plen;
  } deframe_res_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rec_byte = '0;
  logic        rec_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        done_res;
  logic [2:0]  status;
  logic [11:0] payload_len;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  flash_beat_t  flash_q[$];
  deframe_res_t beats_due[$];

  // predictor copy of the registers and the record state
  logic        cfg_mode = 1'b0;
  logic [19:0] cfg_req_len = '0;
  logic [7:0]  cfg_blocks = 8'd1;
  phase_e      st_phase = PH_IDLE;
  logic [15:0] seen_cnt = '0;
  logic [15:0] frame_len = '0;
  logic [7:0]  len_lo = '0;
  logic [7:0]  sum_stored = '0;
  logic [7:0]  sum_run = '0;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_settings = 0;
  int unsigned st_seen[5] = '{default: 0};
  int unsigned quiet = 0;

  flash_record_deframer_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rec_byte_i       (rec_byte),
    .record_start_i   (rec_start),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_byte_o       (out_byte),
    .out_byte_valid_o (out_byte_valid),
    .done_res_o       (done_res),
    .status_o         (status),
    .payload_len_o    (payload_len)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the record state by one byte and return the beat it produces.
  function automatic deframe_res_t deframe_byte(input logic [7:0] b, input logic start);
    deframe_res_t r;
    logic [15:0]  len;
    logic [31:0]  lim;
    logic         keep;
    r = '0;
    if (start) begin
      lim = 32'(cfg_blocks) * BLOCK_BYTES;
      if (cfg_blocks == 0 || cfg_req_len == 0 || 32'(cfg_req_len) + HDR_SLACK > lim) begin
        st_phase = PH_IDLE;
        r.done = 1'b1;
        r.status = ST_REQ;
      end else if (b != MAGIC_BYTE) begin
        st_phase = PH_IDLE;
        r.done = 1'b1;
        r.status = ST_MAGIC;
      end else begin
        st_phase = PH_LEN_LO;
      end
      return r;
    end
    case (st_phase)
      PH_LEN_LO: begin
        len_lo = b;
        st_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len = {b, len_lo};
        if (len > BLOCK_BYTES - HDR_SLACK || (cfg_mode && 32'(len) > 32'(cfg_req_len))) begin
          st_phase = PH_IDLE;
          r.done = 1'b1;
          r.status = ST_LEN;
        end else begin
          frame_len = len;
          st_phase = PH_SUM;
        end
      end
      PH_SUM: begin
        sum_stored = b;
        sum_run = '0;
        seen_cnt = '0;
        if (frame_len == 0) begin
          st_phase = PH_IDLE;
          r.done = 1'b1;
          r.status = (b == 8'h00) ? ST_OK : ST_SUM;
        end else begin
          st_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        keep = cfg_mode || (32'(seen_cnt) < 32'(cfg_req_len));
        sum_run = sum_run + b;
        seen_cnt = seen_cnt + 16'd1;
        if (keep) begin
          r.data = b;
          r.keep = 1'b1;
        end
        if (seen_cnt >= frame_len) begin
          st_phase = PH_IDLE;
          r.done = 1'b1;
          r.status = (sum_run == sum_stored) ? ST_OK : ST_SUM;
          r.plen = frame_len[11:0];
        end
      end
      default: st_phase = PH_IDLE;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // driver: feed flash bytes, hold a beat while stalled
  always @(posedge clk or negedge rst_n) begin : drive
    flash_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        beats_due.push_back(deframe_byte(rec_byte, rec_start));
        n_in++;
      end
      if (!in_valid || in_fire) begin
        if (flash_q.size() != 0 && $urandom_range(99) >= src_idle_pct &&
            !(flash_q[0].hold_for_drain && beats_due.size() != 0)) begin
          nxt = flash_q.pop_front();
          in_valid  <= 1'b1;
          rec_byte  <= nxt.data;
          rec_start <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : watch
    deframe_res_t want;
    if (rst_n) begin
      if (out_fire) begin
        n_out++;
        if (beats_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat with none expected: byte %0d done %0d status %0d",
                     $time, out_byte, done_res, status);
        end else begin
          want = beats_due.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_byte_valid", want.keep, out_byte_valid);
          check_field("done_res", want.done, done_res);
          check_field("status", want.status, status);
          check_field("payload_len", want.plen, payload_len);
          if (done_res && status <= ST_REQ) st_seen[status]++;
        end
      end
      out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", quiet);
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic mode, input logic [19:0] req, input logic [7:0] blocks);
    write_reg(REG_READ_MODE, {31'd0, mode});
    write_reg(REG_REQUESTED, {12'd0, req});
    write_reg(REG_BLOCK_COUNT, {24'd0, blocks});
    cfg_mode    = mode;
    cfg_req_len = req;
    cfg_blocks  = blocks;
    n_settings++;
    @(negedge clk);
  endtask

  task automatic push_beat(input logic [7:0] d, input logic s, input logic hold = 1'b0);
    flash_q.push_back('{data: d, start: s, hold_for_drain: hold});
  endtask

  // magic, length, checksum, then n payload bytes
  task automatic push_frame(input logic [15:0] len_field, input int n, input bit bad_sum,
                            input bit hold);
    logic [7:0] pay[$];
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      pay.push_back(8'($urandom));
      sum = sum + pay[i];
    end
    if (bad_sum) sum = sum + 8'($urandom_range(255, 1));
    push_beat(MAGIC_BYTE, 1'b1, hold);
    push_beat(len_field[7:0], 1'b0);
    push_beat(len_field[15:8], 1'b0);
    push_beat(sum, 1'b0);
    foreach (pay[i]) push_beat(pay[i], 1'b0);
  endtask

  task automatic random_traffic(input int beats, input int max_len, input int hold_pct);
    int base;
    int padding;
    int r;
    int n;
    int bad_len;
    base = flash_q.size();
    padding = 0;
    while (flash_q.size() - base - padding < beats) begin
      r = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(max_len) : $urandom_range(12);
      if (r < 66) begin
        push_frame(16'(n), n, $urandom_range(4) == 0, $urandom_range(99) < hold_pct);
      end else if (r < 74) begin
        if (cfg_mode && cfg_req_len < 4086 && $urandom_range(1))
          bad_len = $urandom_range(4086, cfg_req_len + 1);
        else
          bad_len = $urandom_range(16'hFFFF, 4087);
        push_frame(16'(bad_len), $urandom_range(3), 1'b0, 1'b0);
      end else if (r < 82) begin
        push_beat(8'($urandom), 1'b1);
      end else if (r < 92) begin
        // header promises more than is sent: the next start aborts it
        push_frame(16'(n + 1), $urandom_range(n), 1'b0, 1'b0);
      end else begin
        n = $urandom_range(4, 1);
        padding += n;
        repeat (n) push_beat(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic drain();
    while (flash_q.size() != 0 || in_valid || beats_due.size() != 0) @(negedge clk);
  endtask

  // close any open record with a rejected start, then wait for the last beat
  task automatic finish_phase();
    push_beat(8'h00, 1'b1);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings reject every start; padding while idle gives a zero beat
    push_beat(MAGIC_BYTE, 1'b1);
    push_beat(8'h5A, 1'b0);
    drain();
    set_regs(1'b0, 20'd1, 8'd0);
    push_beat(MAGIC_BYTE, 1'b1);
    drain();
    set_regs(1'b0, 20'd4087, 8'd1);
    push_beat(MAGIC_BYTE, 1'b1);
    drain();
    set_regs(1'b0, 20'd4086, 8'd1);
    push_beat(8'h2B, 1'b1);
    push_frame(16'd0, 0, 1'b0, 1'b0);
    push_frame(16'd0, 0, 1'b1, 1'b0);
    push_frame(16'd4087, 0, 1'b0, 1'b0);
    push_frame(16'hFFFF, 0, 1'b0, 1'b0);
    push_frame(16'd5, 2, 1'b0, 1'b0);
    push_frame(16'd2, 2, 1'b0, 1'b0);
    finish_phase();

    // fixed mode with truncation, no idling
    set_regs(1'b0, 20'($urandom_range(30, 1)), 8'd1);
    random_traffic(200, 40, 0);
    finish_phase();

    set_regs(1'b1, 20'($urandom_range(40, 5)), 8'($urandom_range(255, 1)));
    src_idle_pct = 67;
    random_traffic(200, 60, 0);
    finish_phase();

    // longest legal length, cut short by the next start, then drain-and-resume pauses
    set_regs(1'b0, 20'd4086, 8'd1);
    src_idle_pct = 0;
    sink_stall_pct = 67;
    push_frame(16'd4086, 20, 1'b0, 1'b1);
    random_traffic(200, 80, 10);
    finish_phase();

    set_regs(1'b1, 20'd1044470, 8'd255);
    src_idle_pct = 12;
    sink_stall_pct = 12;
    push_frame(16'd4086, 30, 1'b1, 1'b0);
    random_traffic(200, 300, 5);
    finish_phase();

    // request above the largest area: every start is refused
    set_regs(1'b0, 20'hFFFFF, 8'd255);
    random_traffic(40, 12, 0);
    finish_phase();

    set_regs(1'b1, 20'($urandom_range(4086, 1)), 8'd1);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    random_traffic(300, 200, 0);
    finish_phase();

    repeat (10) @(posedge clk);
    if (beats_due.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted beats never arrived", $time, beats_due.size());
    end
    $display("Run: %0d input beats, %0d result beats, %0d register settings, %0d errors",
             n_in, n_out, n_settings, errors);
    $display("Records closed: %0d ok, %0d bad magic, %0d length, %0d checksum, %0d request",
             st_seen[ST_OK], st_seen[ST_MAGIC], st_seen[ST_LEN], st_seen[ST_SUM],
             st_seen[ST_REQ]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/frd_pkg.sv
rtl/frd_front.sv
rtl/frd_queue.sv
rtl/frd_back.sv
rtl/flash_record_deframer_core.sv
sim/flash_record_deframer_core_tb.sv
